FILE: src/edha_pkg.sv
`default_nettype none

package edha_pkg;

	// Field widths
	localparam int KIND_W = 2;
	localparam int ECHO_W = 14;
	localparam int NOW_W  = 32;
	localparam int SPD_W  = 16;
	localparam int DIST_W = 17;
	localparam int CNT_W  = 16;
	localparam int FAIL_W = 4;
	localparam int CFG_W  = 32;

	// Moving-average window
	localparam int WIN_LEN = 5;
	localparam int WIN_AW  = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
	localparam int WSUM_W  = DIST_W + $clog2(WIN_LEN + 1);

	// Window average as a multiplication by the rounded-up reciprocal of the window
	// length; the shift is wide enough that the truncated product is exact for every sum.
	localparam int AVG_SH = WSUM_W + $clog2(WIN_LEN);
	localparam int AVG_RW = AVG_SH + 1;
	localparam int AVG_PW = WSUM_W + AVG_RW;
	localparam logic [AVG_RW-1:0] AVG_RECIP =
		AVG_RW'(((64'd1 << AVG_SH) + 64'(WIN_LEN) - 64'd1) / 64'(WIN_LEN));

	// Statistics accumulator and the serial divider for the mean
	localparam int DTOT_W = DIST_W + CNT_W;
	localparam int DIV_N  = DTOT_W;
	localparam int DIV_CW = $clog2(DIV_N + 1);

	// Distance product: echo times speed factor, then a Q16 to Q8 shift
	localparam int PROD_W  = ECHO_W + SPD_W;
	localparam int PROD_SH = 8;

	// Stream and register port widths
	localparam int S_TDATA_W = ((ECHO_W + NOW_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 2 * DIST_W + CNT_W + 5;
	localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int APB_AW    = 5;
	localparam int REG_IW    = 3;

	localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
	localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_MEASURE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK      = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATS     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ALARM_RST = 2'd3;

	// Register indexes
	localparam logic [REG_IW-1:0] REG_SPEED    = 3'd0;
	localparam logic [REG_IW-1:0] REG_OPEN     = 3'd1;
	localparam logic [REG_IW-1:0] REG_CLOSE    = 3'd2;
	localparam logic [REG_IW-1:0] REG_ARMED    = 3'd3;
	localparam logic [REG_IW-1:0] REG_COOLDOWN = 3'd4;
	localparam logic [REG_IW-1:0] REG_FAIL_LIM = 3'd5;

	// Register reset values
	localparam logic [SPD_W-1:0]  RST_SPEED    = 16'd1124;
	localparam logic [DIST_W-1:0] RST_OPEN     = 17'd3840;
	localparam logic [DIST_W-1:0] RST_CLOSE    = 17'd2048;
	localparam logic              RST_ARMED    = 1'b1;
	localparam logic [NOW_W-1:0]  RST_COOLDOWN = 32'd30000;
	localparam logic [FAIL_W-1:0] RST_FAIL_LIM = 4'd10;

	typedef struct packed {
		logic [SPD_W-1:0]  speed;
		logic [DIST_W-1:0] open_thr;
		logic [DIST_W-1:0] close_thr;
		logic              armed;
		logic [NOW_W-1:0]  cooldown;
		logic [FAIL_W-1:0] fail_limit;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic mul;
		logic win;
		logic avg;
		logic div_start;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
	} sts_t;

	typedef struct packed {
		logic [DIST_W-1:0] stat_mean;
		logic [CNT_W-1:0]  stat_count;
		logic              reboot_request;
		logic              read_failed;
		logic              notify;
		logic              buzzer_on;
		logic              alarm_on;
		logic [DIST_W-1:0] avg_distance;
	} res_t;

endpackage

`default_nettype wire

FILE: src/echo_distance_hysteresis_alarm.sv
`default_nettype none

// Ultrasonic door alarm. Each input transaction carries one item: a measurement
// (echo time in microseconds plus the current millisecond time), a buzzer tick,
// a read-and-clear of the statistics, or an alarm reset; each item gives exactly
// one output transaction. A measurement is converted to a Q8 centimetre distance,
// pushed into a five-entry moving-average window and, unless the echo timed out,
// run through open/close hysteresis thresholds that set or clear the alarm, with
// a notify pulse subject to a cooldown. Items are processed one at a time. A
// measurement passes the multiply, window and average states; a statistics read
// waits on the one-bit-per-cycle divider, which forms the mean in 33 steps. The
// window average is a multiplication by the reciprocal of the window length. The
// result sits in an output register, so the next item is accepted while a
// finished result still waits to be taken; it stalls only if a second result is
// ready before the first has gone. The user must write registers over the APB
// port only while no item is in progress; the block itself does not enforce this.
module echo_distance_hysteresis_alarm (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	// Register port
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [edha_pkg::APB_AW-1:0]     paddr,
	input  wire logic [edha_pkg::CFG_W-1:0]      pwdata,
	output logic [edha_pkg::CFG_W-1:0]           prdata,
	output logic                                 pready,

	// Input items
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// echo_us [13:0], now_ms [45:14], zero padding above
	input  wire logic [edha_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// kind [1:0]
	input  wire logic [edha_pkg::KIND_W-1:0]     s_axis_tuser,

	// Results
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// avg_distance [16:0], alarm_on [17], buzzer_on [18], notify [19],
	// read_failed [20], reboot_request [21], stat_count [37:22],
	// stat_mean [54:38], zero padding above
	output logic [edha_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
	import edha_pkg::*;

	cfg_t              cfg_q;
	cmd_t              cmd;
	sts_t              sts;
	res_t              res;
	logic              cfg_wr;
	logic [REG_IW-1:0] reg_idx;

	// Registers sit on word addresses; the top address bits pick the register.
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed      <= RST_SPEED;
			cfg_q.open_thr   <= RST_OPEN;
			cfg_q.close_thr  <= RST_CLOSE;
			cfg_q.armed      <= RST_ARMED;
			cfg_q.cooldown   <= RST_COOLDOWN;
			cfg_q.fail_limit <= RST_FAIL_LIM;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SPEED:    cfg_q.speed      <= pwdata[SPD_W-1:0];
				REG_OPEN:     cfg_q.open_thr   <= pwdata[DIST_W-1:0];
				REG_CLOSE:    cfg_q.close_thr  <= pwdata[DIST_W-1:0];
				REG_ARMED:    cfg_q.armed      <= pwdata[0];
				REG_COOLDOWN: cfg_q.cooldown   <= pwdata[NOW_W-1:0];
				REG_FAIL_LIM: cfg_q.fail_limit <= pwdata[FAIL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read-back of the register file; unused addresses read as zero.
	always_comb begin
		unique case (reg_idx)
			REG_SPEED:    prdata = CFG_W'(cfg_q.speed);
			REG_OPEN:     prdata = CFG_W'(cfg_q.open_thr);
			REG_CLOSE:    prdata = CFG_W'(cfg_q.close_thr);
			REG_ARMED:    prdata = CFG_W'(cfg_q.armed);
			REG_COOLDOWN: prdata = CFG_W'(cfg_q.cooldown);
			REG_FAIL_LIM: prdata = CFG_W'(cfg_q.fail_limit);
			default:      prdata = '0;
		endcase
	end

	// The controller sequences each item; the datapath holds window and alarm state.
	edha_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_kind  (s_axis_tuser),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	edha_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.cfg     (cfg_q),
		.in_kind (s_axis_tuser),
		.in_echo (s_axis_tdata[ECHO_W-1:0]),
		.in_now  (s_axis_tdata[ECHO_W+NOW_W-1:ECHO_W]),
		.res     (res)
	);

	// Result fields packed from the lowest bit up.
	assign m_axis_tdata = M_TDATA_W'({res.stat_mean, res.stat_count, res.reboot_request,
		res.read_failed, res.notify, res.buzzer_on, res.alarm_on, res.avg_distance});

`ifndef SYNTH
	// The divider is never running while the block waits for a new item.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !sts.div_busy)
		else $error("divider busy while idle");

	// Only one item is in progress: acceptance closes the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted twice in a row");

	// The divider only starts when the controller asks for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sts.div_busy) |-> $past(cmd.div_start))
		else $error("divider started without a command");

	// A finished item never overwrites a result still waiting to be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

FILE: src/edha_div.sv
`default_nettype none

module edha_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [edha_pkg::DIV_N-1:0]  dividend,
	input  wire logic [edha_pkg::CNT_W-1:0]  divisor,
	output logic                             busy,
	output logic [edha_pkg::DIV_N-1:0]       quotient
);
	import edha_pkg::*;

	logic [DIV_CW-1:0] cnt_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DIV_N-1:0]  quo_q;
	logic [CNT_W:0]    rem_sh;
	logic              fits;

	// One quotient bit per cycle, restoring form.
	assign rem_sh = {rem_q, quo_q[DIV_N-1]};
	assign fits   = (rem_sh >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CW'(DIV_N);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - DIV_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q <= CNT_W'(rem_sh - {1'b0, divisor});
			end else begin
				rem_q <= rem_sh[CNT_W-1:0];
			end
			quo_q <= {quo_q[DIV_N-2:0], fits};
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: src/edha_dp.sv
`default_nettype none

module edha_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire edha_pkg::cmd_t                cmd,
	output edha_pkg::sts_t                     sts,
	input  wire edha_pkg::cfg_t                cfg,
	input  wire logic [edha_pkg::KIND_W-1:0]   in_kind,
	input  wire logic [edha_pkg::ECHO_W-1:0]   in_echo,
	input  wire logic [edha_pkg::NOW_W-1:0]    in_now,
	output edha_pkg::res_t                     res
);
	import edha_pkg::*;

	// Accepted item
	logic [KIND_W-1:0] kind_q;
	logic [ECHO_W-1:0] echo_q;
	logic [NOW_W-1:0]  now_q;

	// Block state
	logic [DIST_W-1:0] dist_q;
	logic [DIST_W-1:0] win_q [WIN_LEN];
	logic [WIN_AW-1:0] pos_q;
	logic [WSUM_W-1:0] sum_q;
	logic [DIST_W-1:0] avg_q;
	logic              alarm_q;
	logic              buzzer_q;
	logic [FAIL_W-1:0] fail_q;
	logic [NOW_W-1:0]  last_q;
	logic [CNT_W-1:0]  good_q;
	logic [DTOT_W-1:0] total_q;
	res_t              res_q;

	// Distance
	logic [PROD_W-1:0]         prod;
	logic [PROD_W-PROD_SH-1:0] prod_sh;
	logic [DIST_W-1:0]         dist_new;

	// Window average
	logic [AVG_PW-1:0] avg_prod;

	// Divider
	logic [DIV_N-1:0] div_dividend;
	logic [CNT_W-1:0] div_divisor;
	logic [DIV_N-1:0] div_quo;
	logic             div_busy;

	// Next-state values taken at the end of an item
	logic              is_meas;
	logic              is_stats;
	logic              good;
	logic [FAIL_W-1:0] eff_lim;
	logic [FAIL_W-1:0] fail_d;
	logic              above_open;
	logic              below_close;
	logic              rise;
	logic              cool_ok;
	logic              notify_d;
	logic              alarm_d;
	logic              buzzer_d;
	logic              stat_add;
	logic [NOW_W-1:0]  since;

	assign prod     = PROD_W'(echo_q) * PROD_W'(cfg.speed);
	assign prod_sh  = prod[PROD_W-1:PROD_SH];
	assign dist_new = (|prod_sh[PROD_W-PROD_SH-1:DIST_W]) ? DIST_MAX : prod_sh[DIST_W-1:0];

	// The window sum divided by the window length.
	assign avg_prod = AVG_PW'(sum_q) * AVG_PW'(AVG_RECIP);

	assign is_meas  = (kind_q == KIND_MEASURE);
	assign is_stats = (kind_q == KIND_STATS);

	assign div_dividend = total_q;
	assign div_divisor  = good_q;

	edha_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign sts.div_busy = div_busy;

	always_comb begin
		good        = is_meas && (echo_q != '0);
		eff_lim     = (cfg.fail_limit == '0) ? FAIL_W'(1) : cfg.fail_limit;
		above_open  = (avg_q > cfg.open_thr);
		below_close = (avg_q < cfg.close_thr);
		since       = now_q - last_q;
		cool_ok     = (since > cfg.cooldown);
		rise        = good && above_open && !alarm_q && cfg.armed;
		notify_d    = rise && cool_ok;
		stat_add    = good && (good_q != COUNT_MAX);

		if (!is_meas) begin
			fail_d = fail_q;
		end else if (echo_q == '0) begin
			fail_d = (fail_q < eff_lim) ? fail_q + FAIL_W'(1) : fail_q;
		end else begin
			fail_d = '0;
		end

		alarm_d  = alarm_q;
		buzzer_d = buzzer_q;
		unique case (kind_q)
			KIND_MEASURE: begin
				if (rise) begin
					alarm_d = 1'b1;
				end else if (good && !above_open && below_close) begin
					alarm_d = 1'b0;
				end
			end
			KIND_TICK: begin
				buzzer_d = alarm_q ? !buzzer_q : 1'b0;
			end
			KIND_STATS: begin
			end
			KIND_ALARM_RST: begin
				alarm_d  = 1'b0;
				buzzer_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= in_kind;
			echo_q <= in_echo;
			now_q  <= in_now;
		end
		if (cmd.mul) begin
			dist_q <= dist_new;
		end
		if (cmd.finish) begin
			res_q.avg_distance   <= avg_q;
			res_q.alarm_on       <= alarm_d;
			res_q.buzzer_on      <= buzzer_d;
			res_q.notify         <= notify_d;
			res_q.read_failed    <= is_meas && (echo_q == '0);
			res_q.reboot_request <= (fail_d >= eff_lim);
			res_q.stat_count     <= is_stats ? good_q : '0;
			res_q.stat_mean      <= (is_stats && (good_q != '0)) ? div_quo[DIST_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				win_q[i] <= '0;
			end
			pos_q    <= '0;
			sum_q    <= '0;
			avg_q    <= '0;
			alarm_q  <= 1'b0;
			buzzer_q <= 1'b0;
			fail_q   <= '0;
			last_q   <= '0;
			good_q   <= '0;
			total_q  <= '0;
		end else begin
			if (cmd.win) begin
				win_q[pos_q] <= dist_q;
				sum_q        <= sum_q - WSUM_W'(win_q[pos_q]) + WSUM_W'(dist_q);
				pos_q        <= (pos_q == WIN_AW'(WIN_LEN - 1)) ? '0 : pos_q + WIN_AW'(1);
			end
			if (cmd.avg) begin
				avg_q <= avg_prod[AVG_SH +: DIST_W];
			end
			if (cmd.finish) begin
				alarm_q  <= alarm_d;
				buzzer_q <= buzzer_d;
				fail_q   <= fail_d;
				if (notify_d) begin
					last_q <= now_q;
				end
				if (is_stats) begin
					good_q  <= '0;
					total_q <= '0;
				end else if (stat_add) begin
					good_q  <= good_q + CNT_W'(1);
					total_q <= total_q + DTOT_W'(avg_q);
				end
			end
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

FILE: src/edha_ctrl.sv
`default_nettype none

module edha_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_valid,
	input  wire logic [edha_pkg::KIND_W-1:0]  s_kind,
	output logic                              s_ready,
	output logic                              m_valid,
	input  wire logic                         m_ready,
	output edha_pkg::cmd_t                    cmd,
	input  wire edha_pkg::sts_t               sts
);
	import edha_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_WIN    = 3'd2;
	localparam logic [2:0] ST_DSTART = 3'd3;
	localparam logic [2:0] ST_DWAIT  = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;
	localparam logic [2:0] ST_AVG    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       m_valid_q;
	logic       out_free;

	// The result register may be refilled once its transaction completes.
	assign out_free = !m_valid_q || m_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_valid) begin
					priority if (s_kind == KIND_MEASURE) begin
						state_d = ST_MUL;
					end else if (s_kind == KIND_STATS) begin
						state_d = ST_DSTART;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_MUL:    state_d = ST_WIN;
			ST_WIN:    state_d = ST_AVG;
			ST_AVG:    state_d = ST_FIN;
			ST_DSTART: state_d = ST_DWAIT;
			ST_DWAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load_in   = (state_q == ST_IDLE) && s_valid;
		cmd.mul       = (state_q == ST_MUL);
		cmd.win       = (state_q == ST_WIN);
		cmd.avg       = (state_q == ST_AVG);
		cmd.div_start = (state_q == ST_DSTART);
		cmd.finish    = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign s_ready = (state_q == ST_IDLE);
	assign m_valid = m_valid_q;

endmodule

`default_nettype wire
